// ===== rtl/cbpf_pkg.sv =====
package cbpf_pkg;

   typedef logic [7:0]       chan_type;
   typedef logic [2:0][7:0]  rgb_type;
   typedef logic [1:0]       mode_type;
   typedef logic [1:0]       row_type;
   typedef logic [8:0]       strength_type;
   typedef logic [12:0]      coef_type;
   typedef logic [7:0]       csr_index_type;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } stage_en_type;

   localparam csr_index_type CSR_FILTER_MODE    = 8'd0;
   localparam csr_index_type CSR_BLEND_STRENGTH = 8'd1;

   localparam mode_type MODE_NONE         = 2'd0;
   localparam mode_type MODE_PROTANOPIA   = 2'd1;
   localparam mode_type MODE_DEUTERANOPIA = 2'd2;
   localparam mode_type MODE_TRITANOPIA   = 2'd3;

   localparam row_type ROW_RED   = 2'd0;
   localparam row_type ROW_GREEN = 2'd1;
   localparam row_type ROW_BLUE  = 2'd2;

   // Q12 color matrices, [mode][output channel][input channel]; rows sum to 4096
   localparam coef_type COLOR_MATRIX [0:3][0:2][0:2] = '{
      '{ '{13'd4096, 13'd0,    13'd0},
         '{13'd0,    13'd4096, 13'd0},
         '{13'd0,    13'd0,    13'd4096} },
      '{ '{13'd2322, 13'd1774, 13'd0},
         '{13'd2286, 13'd1810, 13'd0},
         '{13'd0,    13'd991,  13'd3105} },
      '{ '{13'd2560, 13'd1536, 13'd0},
         '{13'd2867, 13'd1229, 13'd0},
         '{13'd0,    13'd1229, 13'd2867} },
      '{ '{13'd3891, 13'd205,  13'd0},
         '{13'd0,    13'd1774, 13'd2322},
         '{13'd0,    13'd1946, 13'd2150} }
   };

endpackage

// ===== rtl/cbpf_channel.sv =====
module cbpf_channel (
   input  logic                   clock,
   input  cbpf_pkg::stage_en_type stage_en,
   input  cbpf_pkg::row_type      row_sel,
   input  cbpf_pkg::mode_type     filter_mode,
   input  cbpf_pkg::strength_type blend_strength,
   input  cbpf_pkg::rgb_type      pixel,
   output cbpf_pkg::chan_type     chan_out
);

   // stage 1: matrix row
   logic [20:0]        prod0, prod1, prod2;
   logic [21:0]        sim_sum;
   logic [19:0]        sim_in, sim_ff;
   cbpf_pkg::chan_type orig1_in, orig1_ff;

   // stage 2: blend weight
   logic signed [20:0] diff;
   logic signed [30:0] wprod_in, wprod_ff;
   cbpf_pkg::chan_type orig2_ff;

   // stage 3: recombine and clamp
   logic signed [31:0] blend;
   cbpf_pkg::chan_type chan_in, chan_ff;

   always_comb begin
      prod0   = 21'(cbpf_pkg::COLOR_MATRIX[filter_mode][row_sel][0]) * 21'(pixel[0]);
      prod1   = 21'(cbpf_pkg::COLOR_MATRIX[filter_mode][row_sel][1]) * 21'(pixel[1]);
      prod2   = 21'(cbpf_pkg::COLOR_MATRIX[filter_mode][row_sel][2]) * 21'(pixel[2]);
      sim_sum = 22'(prod0) + 22'(prod1) + 22'(prod2);
      sim_in  = sim_sum[19:0];   // at most 255 * 4096
      orig1_in = pixel[row_sel];
   end

   always_comb begin
      diff     = $signed({1'b0, sim_ff}) - $signed({1'b0, orig1_ff, 12'b0});
      wprod_in = 31'(diff) * $signed({22'b0, blend_strength});
   end

   always_comb begin
      blend = $signed({4'b0, orig2_ff, 20'b0}) + 32'(wprod_ff);
      if (blend[31]) begin
         chan_in = '0;
      end else if (|blend[30:28]) begin
         chan_in = 8'hff;
      end else begin
         chan_in = blend[27:20];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1_en) begin
         sim_ff   <= sim_in;
         orig1_ff <= orig1_in;
      end
      if (stage_en.s2_en) begin
         wprod_ff <= wprod_in;
         orig2_ff <= orig1_ff;
      end
      if (stage_en.s3_en) begin
         chan_ff <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

// ===== rtl/colorblind_pixel_filter.sv =====
// Channel  Ports                         Dir  Payload
// req      req_tvalid/tready/tdata       in   RGBA pixel
// rsp      rsp_tvalid/tready/tdata       out  filtered RGBA pixel
// csr      csr_valid/ready/index/data    in   register writes
//
// Three register stages (matrix row, strength weighting, clamp); a pixel
// passes through them in order; one pixel per cycle unless the output stalls.
// Every stage takes a new pixel each cycle unless it is full and stalled.
// Reset clears the stage valid bits and both registers (mode none, strength 0).
// Each stage holds while the one after it is full and stalled; a bubble fills.
module colorblind_pixel_filter (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red_in, green_in, blue_in, alpha_in

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red_out, green_out, blue_out, alpha_out

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [8:0]  csr_data
);

   cbpf_pkg::mode_type     mode_ff, mode_in;
   cbpf_pkg::strength_type strength_ff, strength_in;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic rdy1, rdy2, rdy3;
   cbpf_pkg::stage_en_type stage_en;

   cbpf_pkg::rgb_type  pixel;
   cbpf_pkg::chan_type alpha1_ff, alpha2_ff, alpha3_ff;
   cbpf_pkg::chan_type chan_out [0:2];

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      strength_in = strength_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == cbpf_pkg::CSR_FILTER_MODE) begin
            mode_in = csr_data[1:0];
         end
         if (csr_index == cbpf_pkg::CSR_BLEND_STRENGTH) begin
            strength_in = csr_data;
         end
      end
   end

   always_comb begin
      rdy3 = !v3_ff || rsp_tready;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      stage_en.s1_en = rdy1;
      stage_en.s2_en = rdy2;
      stage_en.s3_en = rdy3;
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff      : v2_ff;
      v3_in = rdy3 ? v2_ff      : v3_ff;
   end

   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= cbpf_pkg::MODE_NONE;
         strength_ff <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         strength_ff <= strength_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         v3_ff       <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1_en) begin
         alpha1_ff <= req_tdata[31:24];
      end
      if (stage_en.s2_en) begin
         alpha2_ff <= alpha1_ff;
      end
      if (stage_en.s3_en) begin
         alpha3_ff <= alpha2_ff;
      end
   end

   assign pixel[0] = req_tdata[7:0];
   assign pixel[1] = req_tdata[15:8];
   assign pixel[2] = req_tdata[23:16];

   cbpf_channel u_red (
      .clock          (clock),
      .stage_en       (stage_en),
      .row_sel        (cbpf_pkg::ROW_RED),
      .filter_mode    (mode_ff),
      .blend_strength (strength_ff),
      .pixel          (pixel),
      .chan_out       (chan_out[0])
   );

   cbpf_channel u_green (
      .clock          (clock),
      .stage_en       (stage_en),
      .row_sel        (cbpf_pkg::ROW_GREEN),
      .filter_mode    (mode_ff),
      .blend_strength (strength_ff),
      .pixel          (pixel),
      .chan_out       (chan_out[1])
   );

   cbpf_channel u_blue (
      .clock          (clock),
      .stage_en       (stage_en),
      .row_sel        (cbpf_pkg::ROW_BLUE),
      .filter_mode    (mode_ff),
      .blend_strength (strength_ff),
      .pixel          (pixel),
      .chan_out       (chan_out[2])
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {alpha3_ff, chan_out[2], chan_out[1], chan_out[0]};

`ifndef NO_ASSERTIONS
   // an empty output stage means the whole pipe can move
   a_empty_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipe refuses input with output stage empty");

   // a pixel in stage 1 advances into stage 2 when stage 2 frees up
   a_s1_advances: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && rdy2) |=> v2_ff)
      else $error("stage 1 pixel lost");

   // a stalled stage 2 keeps its pixel and the output stays full
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy3) |=> (v2_ff && v3_ff))
      else $error("stage 2 pixel dropped during stall");
`endif

endmodule

// ===== tb/tb_colorblind_pixel_filter.sv =====
module tb_colorblind_pixel_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                      WATCHDOG_LIMIT   = 3000;
   localparam int                      HOLD_OFF_CYCLES  = 300;
   localparam int                      ITEMS_PER_SETUP  = 121;
   localparam int                      NUM_SETUPS       = 12;
   localparam cbpf_pkg::csr_index_type CSR_IGNORED_HIGH = 8'hFE;
   localparam cbpf_pkg::csr_index_type CSR_IGNORED_MIX  = 8'h81;

   // red in the low byte, alpha in the high byte
   typedef struct packed {
      cbpf_pkg::chan_type alpha;
      cbpf_pkg::chan_type blue;
      cbpf_pkg::chan_type green;
      cbpf_pkg::chan_type red;
   } pixel_type;

   class cvd_pixel_checker;
      cbpf_pkg::mode_type     mode;
      cbpf_pkg::strength_type strength;
      pixel_type    filtered_q[$];
      int           mismatches;
      int           pixels_checked;
      string        chan_name [4] = '{"red", "green", "blue", "alpha"};
      int           coef [4][3][3] = '{
         '{'{4096, 0, 0},       '{0, 4096, 0},       '{0, 0, 4096}},
         '{'{2322, 1774, 0},    '{2286, 1810, 0},    '{0, 991, 3105}},
         '{'{2560, 1536, 0},    '{2867, 1229, 0},    '{0, 1229, 2867}},
         '{'{3891, 205, 0},     '{0, 1774, 2322},    '{0, 1946, 2150}}
      };

      function new();
         mode           = cbpf_pkg::MODE_NONE;
         strength       = '0;
         mismatches     = 0;
         pixels_checked = 0;
      endfunction

      function void write_register(cbpf_pkg::csr_index_type index, logic [8:0] value);
         if (index == cbpf_pkg::CSR_FILTER_MODE)
            mode = value[1:0];
         else if (index == cbpf_pkg::CSR_BLEND_STRENGTH)
            strength = value;
      endfunction

      // matrix in Q12, blend in Q20, truncate then clamp
      function pixel_type simulate_cvd(pixel_type px);
         longint             orig [3];
         longint             acc;
         cbpf_pkg::chan_type chan [3];
         pixel_type          res;
         orig[0] = longint'(px.red);
         orig[1] = longint'(px.green);
         orig[2] = longint'(px.blue);
         res     = px;
         if (mode != cbpf_pkg::MODE_NONE && strength != 0) begin
            for (int c = 0; c < 3; c++) begin
               acc = 0;
               for (int k = 0; k < 3; k++)
                  acc += longint'(coef[mode][c][k]) * orig[k];
               acc = orig[c] * (64'sd1 <<< 20)
                     + (acc - orig[c] * 4096) * longint'({55'd0, strength});
               if (acc < 0)
                  chan[c] = 8'd0;
               else if ((acc >>> 20) > 255)
                  chan[c] = 8'd255;
               else
                  chan[c] = cbpf_pkg::chan_type'(acc >>> 20);
            end
            res.red   = chan[0];
            res.green = chan[1];
            res.blue  = chan[2];
         end
         return res;
      endfunction

      function void note_pixel(pixel_type px);
         filtered_q = {filtered_q, simulate_cvd(px)};
      endfunction

      task report(string what, int exp_val, int got_val);
         if (mismatches < 40)
            $display("%0t ns MISMATCH %s: expected %0d, got %0d", $time, what, exp_val,
                     got_val);
         mismatches++;
      endtask

      task check_pixel(pixel_type got);
         pixel_type exp_px;
         if (filtered_q.size() == 0) begin
            report("unexpected pixel (raw data)", 0, int'(got));
         end else begin
            exp_px = filtered_q.pop_front();
            pixels_checked++;
            for (int f = 0; f < 4; f++)
               if (got[8*f +: 8] !== exp_px[8*f +: 8])
                  report(chan_name[f], int'(exp_px[8*f +: 8]), int'(got[8*f +: 8]));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [8:0]  csr_data;

   cvd_pixel_checker checker_h = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;

   colorblind_pixel_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // transfers are taken on the rising edge, before the DUT's registers move
   always @(posedge clock) begin
      if (req_tvalid && req_tready)
         checker_h.note_pixel(req_tdata);
      if (rsp_tvalid && rsp_tready)
         checker_h.check_pixel(rsp_tdata);
      if (csr_valid && csr_ready)
         checker_h.write_register(csr_index, csr_data);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when one is requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_pixel(pixel_type px);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(cbpf_pkg::csr_index_type index, logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every pending pixel, then let the pipeline settle
   task automatic drain();
      while (checker_h.filtered_q.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   pixel_type              directed_px [6] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_00FF,
      32'hFF00_FF00, 32'h00FF_0000, 32'h7F12_3456
   };
   cbpf_pkg::mode_type     directed_mode [4] = '{
      cbpf_pkg::MODE_NONE, cbpf_pkg::MODE_PROTANOPIA, cbpf_pkg::MODE_DEUTERANOPIA,
      cbpf_pkg::MODE_TRITANOPIA
   };
   cbpf_pkg::strength_type directed_str [4]  = '{9'd0, 9'd256, 9'd511, 9'd1};
   cbpf_pkg::mode_type     setup_mode [NUM_SETUPS] = '{
      cbpf_pkg::MODE_PROTANOPIA, cbpf_pkg::MODE_DEUTERANOPIA, cbpf_pkg::MODE_TRITANOPIA,
      cbpf_pkg::MODE_NONE, cbpf_pkg::MODE_PROTANOPIA, cbpf_pkg::MODE_DEUTERANOPIA,
      cbpf_pkg::MODE_TRITANOPIA, cbpf_pkg::MODE_PROTANOPIA, cbpf_pkg::MODE_DEUTERANOPIA,
      cbpf_pkg::MODE_TRITANOPIA, cbpf_pkg::MODE_NONE, cbpf_pkg::MODE_NONE
   };
   cbpf_pkg::strength_type setup_str [NUM_SETUPS] = '{
      9'd256, 9'd256, 9'd256, 9'd300, 9'd0, 9'd511,
      9'd257, 9'd1, 9'd128, 9'd511, 9'd0, 9'd0
   };

   initial begin
      pixel_type px;
      int        pick;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: edge pixels under each mode, first with reset settings
      for (int d = 0; d < 4; d++) begin
         if (d > 0) begin
            write_csr(cbpf_pkg::CSR_FILTER_MODE, {7'd0, directed_mode[d]});
            write_csr(cbpf_pkg::CSR_BLEND_STRENGTH, directed_str[d]);
         end
         foreach (directed_px[i])
            send_pixel(directed_px[i]);
         stop_sending();
         drain();
      end

      for (int s = 0; s < NUM_SETUPS; s++) begin
         send_idle_pct = (s < 4) ? 17 : (s < 8) ? 51 : 0;
         recv_idle_pct = (s < 4) ? 51 : (s < 8) ? 17 : 0;
         if (s >= 10) begin
            setup_mode[s] = cbpf_pkg::mode_type'($urandom_range(3));
            setup_str[s]  = cbpf_pkg::strength_type'($urandom_range(511));
         end
         // mode write with upper data bits set: only the low two bits count
         if (s == 5)
            write_csr(cbpf_pkg::CSR_FILTER_MODE, {7'h7F, setup_mode[s]});
         else
            write_csr(cbpf_pkg::CSR_FILTER_MODE, {7'd0, setup_mode[s]});
         write_csr(cbpf_pkg::CSR_BLEND_STRENGTH, setup_str[s]);
         // writes to unused indexes must leave both registers alone
         if (s == 3) begin
            write_csr(CSR_IGNORED_HIGH, 9'h1FF);
            write_csr(CSR_IGNORED_MIX, 9'h0AA);
         end
         if (s == 9)
            hold_request = HOLD_OFF_CYCLES;
         for (int n = 0; n < ITEMS_PER_SETUP; n++) begin
            pick = $urandom_range(9);
            px   = $urandom();
            if (pick == 0) begin
               px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
               px.green = $urandom_range(1) ? 8'hFF : 8'h00;
               px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end else if (pick == 1) begin
               // gray: all three channels equal
               px.green = px.red;
               px.blue  = px.red;
            end
            send_pixel(px);
         end
         stop_sending();
         drain();
      end

      $display("Run covered %0d pixels across %0d register setups: all four modes,",
               checker_h.pixels_checked, NUM_SETUPS + 4);
      $display("strength 0 to 511, ignored register indexes and a %0d-cycle output stall.",
               HOLD_OFF_CYCLES);
      if (checker_h.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
